FILE: sv/ismp_pkg.sv
// Package for the I2C slave motor packet handler.
// Holds the word types, operation and error codes and shared constants.
// Has no dependencies; the design files use it by scoped names and the testbench imports it.
package ismp_pkg;

  // Default parameter values for the top level.
  localparam int NumMotorsDef = 4;
  localparam int RxBytesDef   = 16;

  // Number of motor slots that the two-bit motor field can address.
  localparam int MotorSlots = 4;

  // Widest receive buffer index (up to 64 bytes per motor).
  localparam int IdxMaxW = 6;

  // Status bits that mark an error in a sent status byte.
  localparam logic [7:0] StatusErrMask = 8'h78;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_ADDR  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_TAKEN = 3'd5,
    OP_BUFRD = 3'd6,
    OP_NONE  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ERR_OVERFLOW = 2'd0,
    ERR_NOT_DONE = 2'd1,
    ERR_CLEAR    = 2'd2
  } err_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_VERSION   = 1'b0,
    CFG_TEST_CODE = 1'b1
  } cfg_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  bus_byte;
    logic        rd_not_write;
    logic        overflow;
    logic [1:0]  motor_sel;
    logic [4:0]  buf_index;
    logic [7:0]  state_byte;
    logic [15:0] cur_pos;
    logic [15:0] test_pos;
    logic        test_pos_pending;
  } in_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cmd_ready;
    logic [1:0] cmd_motor;
    logic [4:0] cmd_length;
    logic       err_valid;
    logic [1:0] err_code;
    logic [1:0] err_motor;
    logic [7:0] rd_data;
    logic       test_pos_taken;
  } out_word_t;

  // Receive buffer write request from the packet logic.
  typedef struct packed {
    logic               en;
    logic [1:0]         motor;
    logic [IdxMaxW-1:0] idx;
    logic [7:0]         data;
  } buf_wr_t;

endpackage

FILE: sv/ismp_rxbuf.sv
// Receive buffer memory for all motors, one write and one read port.
// The read is registered and forwards a write to the same entry in that cycle.
// Depends on ismp_pkg.
module ismp_rxbuf #(
  parameter int MOTORS   = ismp_pkg::NumMotorsDef,
  parameter int RX_BYTES = ismp_pkg::RxBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [1:0]          rd_motor_i,
  input  logic [4:0]          rd_index_i,
  input  ismp_pkg::buf_wr_t   wr_i,
  output logic [7:0]          rd_data_o
);

  localparam int Depth = MOTORS * RX_BYTES;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [7:0]    mem [Depth];
  logic [7:0]    rd_data_q;
  logic [6:0]    rd_off;
  logic          rd_ok;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // Buffer index 1 is the first received byte.
  assign rd_off = 7'(rd_index_i) - 7'd1;
  assign rd_ok  = (3'(rd_motor_i) < 3'(MOTORS)) && (rd_index_i != 5'd0) &&
                  (7'(rd_index_i) <= 7'(RX_BYTES));
  assign rd_addr = rd_ok ? AW'(int'(rd_motor_i) * RX_BYTES + int'(rd_off)) : '0;
  assign wr_addr = AW'(int'(wr_i.motor) * RX_BYTES + int'(wr_i.idx));

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_data_q <= 8'd0;
    end else if (rd_en_i) begin
      rd_data_q <= (wr_i.en && (wr_addr == rd_addr)) ? wr_i.data : mem[rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/ismp_ctrl.sv
// Packet state and per-event result logic for the motor packet handler.
// Updates packet, send and per-motor command state when a word advances.
// Depends on ismp_pkg.
module ismp_ctrl #(
  parameter int MOTORS   = ismp_pkg::NumMotorsDef,
  parameter int RX_BYTES = ismp_pkg::RxBytesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  ismp_pkg::in_word_t   word_i,
  input  logic [7:0]           buf_data_i,
  input  logic [7:0]           version_i,
  input  logic [7:0]           test_code_i,
  output ismp_pkg::out_word_t  res_o,
  output ismp_pkg::buf_wr_t    wr_o
);

  localparam int CW = $clog2(RX_BYTES + 1);

  logic          in_packet_q, in_packet_d;
  logic          for_us_q, for_us_d;
  logic [1:0]    pkt_motor_q, pkt_motor_d;
  logic [CW-1:0] recv_count_q, recv_count_d;
  logic [1:0]    send_count_q, send_count_d;
  logic [7:0]    send_bytes_q [3];
  logic [7:0]    send_bytes_d [3];
  logic          cmd_pend_q [ismp_pkg::MotorSlots];
  logic          cmd_pend_d [ismp_pkg::MotorSlots];
  logic [CW-1:0] rlen_q [ismp_pkg::MotorSlots];
  logic [CW-1:0] rlen_d [ismp_pkg::MotorSlots];

  logic [1:0]  addr_motor;
  logic        addr_ok;
  logic        sel_ok;
  logic [15:0] pos;
  logic [7:0]  status;

  assign addr_motor = word_i.bus_byte[2:1];
  assign addr_ok    = 3'(addr_motor) < 3'(MOTORS);
  assign sel_ok     = 3'(word_i.motor_sel) < 3'(MOTORS);
  assign pos        = word_i.test_pos_pending ? word_i.test_pos : word_i.cur_pos;
  assign status     = (word_i.test_pos_pending ? test_code_i : word_i.state_byte) |
                      version_i;

  always_comb begin
    in_packet_d  = in_packet_q;
    for_us_d     = for_us_q;
    pkt_motor_d  = pkt_motor_q;
    recv_count_d = recv_count_q;
    send_count_d = send_count_q;
    send_bytes_d = send_bytes_q;
    cmd_pend_d   = cmd_pend_q;
    rlen_d       = rlen_q;
    res_o        = '0;
    wr_o         = '0;

    case (ismp_pkg::op_e'(word_i.op))
      ismp_pkg::OP_START: begin
        if (!in_packet_q) begin
          recv_count_d = '0;
          send_count_d = 2'd1;
          in_packet_d  = 1'b1;
          for_us_d     = 1'b0;
        end
      end
      ismp_pkg::OP_STOP: begin
        in_packet_d = 1'b0;
        if (word_i.overflow) begin
          res_o.err_valid = 1'b1;
          res_o.err_code  = ismp_pkg::ERR_OVERFLOW;
          res_o.err_motor = pkt_motor_q;
        end else if (for_us_q) begin
          if (!word_i.rd_not_write) begin
            rlen_d[pkt_motor_q]     = recv_count_q;
            cmd_pend_d[pkt_motor_q] = 1'b1;
            res_o.cmd_ready  = 1'b1;
            res_o.cmd_motor  = pkt_motor_q;
            res_o.cmd_length = 5'(recv_count_q);
          end else if ((send_bytes_q[0] & ismp_pkg::StatusErrMask) != 8'd0) begin
            res_o.err_valid = 1'b1;
            res_o.err_code  = ismp_pkg::ERR_CLEAR;
            res_o.err_motor = pkt_motor_q;
          end
        end
      end
      ismp_pkg::OP_ADDR: begin
        if (addr_ok) begin
          for_us_d    = 1'b1;
          pkt_motor_d = addr_motor;
          if (word_i.rd_not_write) begin
            send_bytes_d[0] = status;
            send_bytes_d[1] = pos[15:8];
            send_bytes_d[2] = pos[7:0];
            res_o.tx_valid       = 1'b1;
            res_o.tx_byte        = status;
            res_o.test_pos_taken = word_i.test_pos_pending;
          end
        end else begin
          for_us_d = 1'b0;
        end
      end
      ismp_pkg::OP_WRITE: begin
        if (for_us_q && !word_i.rd_not_write) begin
          if (cmd_pend_q[pkt_motor_q]) begin
            res_o.err_valid = 1'b1;
            res_o.err_code  = ismp_pkg::ERR_NOT_DONE;
            res_o.err_motor = pkt_motor_q;
          end else if (recv_count_q < CW'(RX_BYTES)) begin
            wr_o.en      = adv_i;
            wr_o.motor   = pkt_motor_q;
            wr_o.idx     = ismp_pkg::IdxMaxW'(recv_count_q);
            wr_o.data    = word_i.bus_byte;
            recv_count_d = recv_count_q + CW'(1);
          end
        end
      end
      ismp_pkg::OP_READ: begin
        if (for_us_q && word_i.rd_not_write) begin
          res_o.tx_valid = 1'b1;
          if (send_count_q != 2'd3) begin
            res_o.tx_byte = send_bytes_q[send_count_q];
            send_count_d  = send_count_q + 2'd1;
          end
        end
      end
      ismp_pkg::OP_TAKEN: begin
        if (sel_ok) begin
          cmd_pend_d[word_i.motor_sel] = 1'b0;
        end
      end
      ismp_pkg::OP_BUFRD: begin
        if (sel_ok) begin
          if (word_i.buf_index == 5'd0) begin
            res_o.rd_data = 8'(rlen_q[word_i.motor_sel]);
          end else if (7'(word_i.buf_index) <= 7'(RX_BYTES)) begin
            res_o.rd_data = buf_data_i;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q  <= 1'b0;
      for_us_q     <= 1'b0;
      pkt_motor_q  <= 2'd0;
      recv_count_q <= '0;
      send_count_q <= 2'd0;
      send_bytes_q <= '{default: 8'd0};
      cmd_pend_q   <= '{default: 1'b0};
      rlen_q       <= '{default: '0};
    end else if (adv_i) begin
      in_packet_q  <= in_packet_d;
      for_us_q     <= for_us_d;
      pkt_motor_q  <= pkt_motor_d;
      recv_count_q <= recv_count_d;
      send_count_q <= send_count_d;
      send_bytes_q <= send_bytes_d;
      cmd_pend_q   <= cmd_pend_d;
      rlen_q       <= rlen_d;
    end
  end

endmodule

FILE: sv/i2c_slave_motor_packet_handler_top.sv
// Top level of the I2C slave motor packet handler.
// Holds the handshakes, the input and result registers and the configuration.
// Depends on ismp_pkg, ismp_rxbuf and ismp_ctrl.
//
//   Channel   Direction  Handshake                      Payload
//   in        input      in_valid_i / in_ready_o        in_word_i  (ismp_pkg::in_word_t)
//   out       output     out_valid_o / out_ready_i      out_word_o (ismp_pkg::out_word_t)
//   cfg       input      cfg_we_i, no wait              cfg_idx_i, cfg_data_i
//
// Each accepted word gives exactly one result word, which passes through the input
// register and then the result register before it can be taken. One word per cycle
// is sustained while results are taken. Reset is asynchronous; it clears packet,
// command and configuration state and both valid flags, but not the receive buffer.
// An untaken result holds the input register, and the input stalls only once that
// register is also full.
module i2c_slave_motor_packet_handler_top #(
  parameter int MOTORS   = ismp_pkg::NumMotorsDef,
  parameter int RX_BYTES = ismp_pkg::RxBytesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ismp_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ismp_pkg::out_word_t  out_word_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [7:0]           cfg_data_i
);

  // Configuration registers.
  logic [7:0] version_q;
  logic [7:0] test_code_q;

  // Input register (stage one) and result register.
  logic                 s1_v_q;
  ismp_pkg::in_word_t   s1_word_q;
  logic                 out_v_q;
  ismp_pkg::out_word_t  out_word_q;

  logic                 in_acc;
  logic                 s1_adv;
  logic [7:0]           buf_data;
  ismp_pkg::out_word_t  res;
  ismp_pkg::buf_wr_t    buf_wr;

  // The word in stage one moves on when the result register is free or drains.
  assign s1_adv     = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q   <= 8'd0;
      test_code_q <= 8'd0;
    end else if (cfg_we_i) begin
      case (ismp_pkg::cfg_e'(cfg_idx_i))
        ismp_pkg::CFG_VERSION:   version_q   <= cfg_data_i;
        ismp_pkg::CFG_TEST_CODE: test_code_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_word_q <= in_word_i;
    end
    if (s1_adv) begin
      out_word_q <= res;
    end
  end

  // The buffer read is issued as the word enters stage one, so its data is
  // ready when the word is processed. A write by the word leaving stage one in
  // the same cycle is forwarded inside the buffer.
  ismp_rxbuf #(
    .MOTORS   (MOTORS),
    .RX_BYTES (RX_BYTES)
  ) u_rxbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_acc),
    .rd_motor_i (in_word_i.motor_sel),
    .rd_index_i (in_word_i.buf_index),
    .wr_i       (buf_wr),
    .rd_data_o  (buf_data)
  );

  ismp_ctrl #(
    .MOTORS   (MOTORS),
    .RX_BYTES (RX_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (s1_adv),
    .word_i      (s1_word_q),
    .buf_data_i  (buf_data),
    .version_i   (version_q),
    .test_code_i (test_code_q),
    .res_o       (res),
    .wr_o        (buf_wr)
  );

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_word_q;

  // A word that leaves stage one always shows up as a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) s1_adv |=> out_v_q)
    else $error("stage one advanced without a result");

  // An accepted word always occupies stage one in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> s1_v_q)
    else $error("accepted word lost before stage one");

  // A result carries at most one kind of report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> $onehot0({out_word_q.tx_valid, out_word_q.cmd_ready,
                          out_word_q.err_valid}))
    else $error("result mixes transmit, command and error reports");

  // The test position is only taken with a status byte sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_word_q.test_pos_taken) |-> out_word_q.tx_valid)
    else $error("test position taken without a transmit byte");

  // The buffer is only written while a word leaves stage one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) buf_wr.en |-> s1_adv)
    else $error("buffer write outside a stage one advance");

endmodule

FILE: dv/i2c_slave_motor_packet_handler_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for i2c_slave_motor_packet_handler_top.
// Drives bus event words and compares every result word with a local predictor or a typed-in result.
// Depends on ismp_pkg and the RTL of the block.
module i2c_slave_motor_packet_handler_top_tb;
  import ismp_pkg::*;

  localparam int NumMotors   = NumMotorsDef;
  localparam int RxBytes     = RxBytesDef;
  // Cycles without any accepted word or taken result before the run is declared hung.
  localparam int QuietLimit  = 1000;
  // Settling time after the last owed result has come back.
  localparam int DrainCycles = 6;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_word_t   in_word_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_word_t  out_word_o;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_data_i;

  i2c_slave_motor_packet_handler_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state. It mirrors the packet and per-motor command state of the
  // block and is advanced once for every word the block accepts.
  logic       pkt_open;
  logic       pkt_ours;
  logic [1:0] pkt_motor;
  logic [4:0] rx_count;
  logic [1:0] tx_count;
  logic [7:0] reply_bytes [3];
  logic       cmd_busy    [MotorSlots];
  logic [4:0] cmd_len     [MotorSlots];
  logic [7:0] rx_mem      [MotorSlots][RxBytes];
  // Tracks which buffer entries were filled since reset. The block does not
  // clear its buffer, so reads of other entries are steered away.
  bit         rx_written  [MotorSlots][RxBytes];
  logic [7:0] status_or;
  logic [7:0] tp_code;

  // Result words that are owed by the block, oldest first.
  out_word_t  due_replies[$];

  // Directed table: stimulus word, whether the result is typed in, and that result.
  in_word_t   probe_word[$];
  bit         probe_typed[$];
  out_word_t  probe_want[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;
  int n_items        = 0;
  int n_results      = 0;
  int n_fail         = 0;
  int n_cmd          = 0;
  int n_err          = 0;
  int n_tx           = 0;
  int n_settings     = 0;

  // Computes the result word of one bus event and advances the predictor state.
  function automatic out_word_t bus_event_result(in_word_t w);
    out_word_t   r;
    logic [1:0]  m;
    logic [15:0] pos;
    r = '0;
    m = w.bus_byte[2:1];
    case (w.op)
      OP_START: begin
        // A start inside an open packet is ignored altogether.
        if (!pkt_open) begin
          rx_count = '0;
          tx_count = 2'd1;
          pkt_open = 1'b1;
          pkt_ours = 1'b0;
        end
      end
      OP_STOP: begin
        pkt_open = 1'b0;
        if (w.overflow) begin
          r.err_valid = 1'b1;
          r.err_code  = ERR_OVERFLOW;
          r.err_motor = pkt_motor;
        end else if (pkt_ours) begin
          if (!w.rd_not_write) begin
            cmd_len[pkt_motor]  = rx_count;
            cmd_busy[pkt_motor] = 1'b1;
            r.cmd_ready  = 1'b1;
            r.cmd_motor  = pkt_motor;
            r.cmd_length = rx_count;
          end else if ((reply_bytes[0] & StatusErrMask) != 8'h00) begin
            r.err_valid = 1'b1;
            r.err_code  = ERR_CLEAR;
            r.err_motor = pkt_motor;
          end
        end
      end
      OP_ADDR: begin
        if (int'(m) < NumMotors) begin
          pkt_ours  = 1'b1;
          pkt_motor = m;
          if (w.rd_not_write) begin
            pos = w.test_pos_pending ? w.test_pos : w.cur_pos;
            reply_bytes[0] = (w.test_pos_pending ? tp_code : w.state_byte) | status_or;
            reply_bytes[1] = pos[15:8];
            reply_bytes[2] = pos[7:0];
            r.tx_valid       = 1'b1;
            r.tx_byte        = reply_bytes[0];
            r.test_pos_taken = w.test_pos_pending;
          end
        end else begin
          pkt_ours = 1'b0;
        end
      end
      OP_WRITE: begin
        if (pkt_ours && !w.rd_not_write) begin
          if (cmd_busy[pkt_motor]) begin
            r.err_valid = 1'b1;
            r.err_code  = ERR_NOT_DONE;
            r.err_motor = pkt_motor;
          end else if (int'(rx_count) < RxBytes) begin
            rx_mem[pkt_motor][rx_count]     = w.bus_byte;
            rx_written[pkt_motor][rx_count] = 1'b1;
            rx_count = rx_count + 5'd1;
          end
        end
      end
      OP_READ: begin
        if (pkt_ours && w.rd_not_write) begin
          r.tx_valid = 1'b1;
          if (tx_count < 2'd3) begin
            r.tx_byte = reply_bytes[tx_count];
            tx_count  = tx_count + 2'd1;
          end
        end
      end
      OP_TAKEN: begin
        if (int'(w.motor_sel) < NumMotors) cmd_busy[w.motor_sel] = 1'b0;
      end
      OP_BUFRD: begin
        if (int'(w.motor_sel) < NumMotors) begin
          if (w.buf_index == 5'd0) begin
            r.rd_data = 8'(cmd_len[w.motor_sel]);
          end else if (int'(w.buf_index) <= RxBytes) begin
            r.rd_data = rx_mem[w.motor_sel][w.buf_index - 5'd1];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic string fmt_reply(out_word_t r);
    return $sformatf("txv=%0b txb=%h crdy=%0b cmot=%0d clen=%0d ev=%0b ec=%0d em=%0d rd=%h tpt=%0b",
                     r.tx_valid, r.tx_byte, r.cmd_ready, r.cmd_motor, r.cmd_length,
                     r.err_valid, r.err_code, r.err_motor, r.rd_data, r.test_pos_taken);
  endfunction

  function automatic in_word_t rand_word();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(in_word_t)-1:0];
  endfunction

  task automatic add_probe(input in_word_t w, input bit typed, input out_word_t want);
    probe_word.push_back(w);
    probe_typed.push_back(typed);
    probe_want.push_back(want);
  endtask

  task automatic report(input string what, input out_word_t want, input out_word_t got);
    n_fail++;
    if (n_fail <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected %s", fmt_reply(want));
      $display("  actual   %s", fmt_reply(got));
    end
  endtask

  // Offers one word to the block. Called right after a falling edge and
  // returns right after the falling edge that follows its acceptance, with
  // valid still high so that a following word can go out without a gap.
  task automatic push_word(input in_word_t w, input bit typed, input out_word_t want);
    out_word_t predicted;
    // Never read a buffer entry that has not been filled since reset.
    if (w.op == OP_BUFRD && w.buf_index != 5'd0 && int'(w.buf_index) <= RxBytes) begin
      if (!rx_written[w.motor_sel][w.buf_index - 5'd1]) w.buf_index = 5'd0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = bus_event_result(w);
    due_replies.push_back(typed ? want : predicted);
    n_items++;
    @(negedge clk_i);
  endtask

  // Writes both registers. Only called while the block is idle.
  task automatic set_config(input logic [7:0] ver, input logic [7:0] code);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_VERSION;
    cfg_data_i <= ver;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_TEST_CODE;
    cfg_data_i <= code;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    status_or  = ver;
    tp_code    = code;
    n_settings++;
  endtask

  // Waits until every owed result has come back, then lets the block settle.
  task automatic drain();
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Random traffic. Most of it is well-formed write and read packets with
  // random content, so that commands, busy errors, full buffers and status
  // replies are all reached; the rest is command handshakes, buffer reads
  // and raw noise words that break packets apart.
  task automatic run_traffic(input int n);
    int       stop_at;
    int       pick;
    int       k;
    bit       rd;
    in_word_t w;
    stop_at = n_items + n;
    while (n_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        rd = (pick >= 35);
        w = rand_word();
        w.op = OP_START;
        push_word(w, 1'b0, '0);
        w = rand_word();
        w.op = OP_ADDR;
        w.rd_not_write = rd;
        push_word(w, 1'b0, '0);
        // Write packets now and then run past the buffer size.
        if (rd) k = $urandom_range(4);
        else if ($urandom_range(3) == 0) k = $urandom_range(RxBytes + 4, RxBytes - 2);
        else k = $urandom_range(8);
        repeat (k) begin
          w = rand_word();
          w.op = rd ? OP_READ : OP_WRITE;
          w.rd_not_write = rd;
          push_word(w, 1'b0, '0);
        end
        w = rand_word();
        w.op = OP_STOP;
        w.rd_not_write = rd;
        w.overflow = ($urandom_range(15) == 0);
        push_word(w, 1'b0, '0);
      end else if (pick < 72) begin
        w = rand_word();
        w.op = OP_TAKEN;
        push_word(w, 1'b0, '0);
      end else if (pick < 84) begin
        w = rand_word();
        w.op = OP_BUFRD;
        if ($urandom_range(7) == 0) w.buf_index = 5'($urandom_range(31));
        else w.buf_index = 5'($urandom_range(RxBytes));
        push_word(w, 1'b0, '0);
      end else begin
        push_word(rand_word(), 1'b0, '0);
      end
    end
  endtask

  // The receiver stalls at random at the rate of the current phase.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checking and the hang watchdog.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (due_replies.size() == 0) begin
          report("result word with nothing expected", '0, out_word_o);
        end else begin
          want = due_replies.pop_front();
          if (want.tx_valid)  n_tx++;
          if (want.cmd_ready) n_cmd++;
          if (want.err_valid) n_err++;
          if (out_word_o.tx_valid       !== want.tx_valid       ||
              out_word_o.tx_byte        !== want.tx_byte        ||
              out_word_o.cmd_ready      !== want.cmd_ready      ||
              out_word_o.cmd_motor      !== want.cmd_motor      ||
              out_word_o.cmd_length     !== want.cmd_length     ||
              out_word_o.err_valid      !== want.err_valid      ||
              out_word_o.err_code       !== want.err_code       ||
              out_word_o.err_motor      !== want.err_motor      ||
              out_word_o.rd_data        !== want.rd_data        ||
              out_word_o.test_pos_taken !== want.test_pos_taken) begin
            report("result word mismatch", want, out_word_o);
          end
        end
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no word moved for %0d cycles", $realtime, QuietLimit);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int i;
    // Every input is known from time zero; reset is released after a falling edge.
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_word_i  = '0;
    out_ready_i = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_VERSION;
    cfg_data_i = 8'h00;

    pkt_open  = 1'b0;
    pkt_ours  = 1'b0;
    pkt_motor = '0;
    rx_count  = '0;
    tx_count  = '0;
    status_or = 8'h00;
    tp_code   = 8'h00;
    for (i = 0; i < 3; i++) reply_bytes[i] = 8'h00;
    for (i = 0; i < MotorSlots; i++) begin
      cmd_busy[i] = 1'b0;
      cmd_len[i]  = '0;
      for (int j = 0; j < RxBytes; j++) begin
        rx_mem[i][j]     = 8'h00;
        rx_written[i][j] = 1'b0;
      end
    end

    // Directed table. The typed results assume version bits 0x01 and test
    // code 0x40. A fully set idle word, reads and writes before any address,
    // a repeated start, a write packet to motor 3 with a write that carries
    // the read flag, a second write while that command is still pending, an
    // overflowed stop, buffer reads of the length and data, a read packet that
    // runs past its three bytes and ends in an error clear, and a test
    // position reply.
    add_probe('1, 1'b1, '0);
    add_probe('{op: OP_BUFRD, default: '0}, 1'b1, '0);
    add_probe('{op: OP_READ, rd_not_write: 1'b1, default: '0}, 1'b1, '0);
    add_probe('{op: OP_WRITE, bus_byte: 8'h55, default: '0}, 1'b1, '0);
    add_probe('{op: OP_START, default: '0}, 1'b1, '0);
    add_probe('{op: OP_START, default: '0}, 1'b1, '0);
    add_probe('{op: OP_ADDR, bus_byte: 8'hFE, default: '0}, 1'b1, '0);
    add_probe('{op: OP_WRITE, bus_byte: 8'hFF, default: '0}, 1'b1, '0);
    add_probe('{op: OP_WRITE, bus_byte: 8'h00, rd_not_write: 1'b1, default: '0}, 1'b1, '0);
    add_probe('{op: OP_WRITE, bus_byte: 8'h00, default: '0}, 1'b1, '0);
    add_probe('{op: OP_STOP, default: '0}, 1'b1,
              '{cmd_ready: 1'b1, cmd_motor: 2'd3, cmd_length: 5'd2, default: '0});
    add_probe('{op: OP_START, default: '0}, 1'b0, '0);
    add_probe('{op: OP_ADDR, bus_byte: 8'h06, default: '0}, 1'b0, '0);
    add_probe('{op: OP_WRITE, bus_byte: 8'h5A, default: '0}, 1'b1,
              '{err_valid: 1'b1, err_code: ERR_NOT_DONE, err_motor: 2'd3, default: '0});
    add_probe('{op: OP_STOP, overflow: 1'b1, default: '0}, 1'b1,
              '{err_valid: 1'b1, err_code: ERR_OVERFLOW, err_motor: 2'd3, default: '0});
    add_probe('{op: OP_BUFRD, motor_sel: 2'd3, default: '0}, 1'b1,
              '{rd_data: 8'd2, default: '0});
    add_probe('{op: OP_BUFRD, motor_sel: 2'd3, buf_index: 5'd1, default: '0}, 1'b1,
              '{rd_data: 8'hFF, default: '0});
    add_probe('{op: OP_START, default: '0}, 1'b0, '0);
    add_probe('{op: OP_ADDR, bus_byte: 8'h01, rd_not_write: 1'b1, state_byte: 8'h08,
                cur_pos: 16'hFFFF, default: '0}, 1'b1,
              '{tx_valid: 1'b1, tx_byte: 8'h09, default: '0});
    add_probe('{op: OP_READ, rd_not_write: 1'b1, default: '0}, 1'b0, '0);
    add_probe('{op: OP_READ, rd_not_write: 1'b1, default: '0}, 1'b0, '0);
    add_probe('{op: OP_READ, rd_not_write: 1'b1, default: '0}, 1'b1,
              '{tx_valid: 1'b1, default: '0});
    add_probe('{op: OP_STOP, rd_not_write: 1'b1, default: '0}, 1'b1,
              '{err_valid: 1'b1, err_code: ERR_CLEAR, err_motor: 2'd0, default: '0});
    add_probe('{op: OP_START, default: '0}, 1'b0, '0);
    add_probe('{op: OP_ADDR, bus_byte: 8'h03, rd_not_write: 1'b1, state_byte: 8'hFF,
                test_pos: 16'h1234, test_pos_pending: 1'b1, default: '0}, 1'b1,
              '{tx_valid: 1'b1, tx_byte: 8'h41, test_pos_taken: 1'b1, default: '0});
    add_probe('{op: OP_STOP, rd_not_write: 1'b1, default: '0}, 1'b1,
              '{err_valid: 1'b1, err_code: ERR_CLEAR, err_motor: 2'd1, default: '0});

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_config(8'h01, 8'h40);
    for (i = 0; i < probe_word.size(); i++) begin
      push_word(probe_word[i], probe_typed[i], probe_want[i]);
    end
    in_valid_i <= 1'b0;
    drain();

    // Four idling phases, each with its own register setting: no idling,
    // a mostly idle sender, a mostly stalled receiver, and both at once.
    for (i = 0; i < 4; i++) begin
      case (i)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          set_config(8'h00, 8'hFF);
        end
        1: begin
          send_idle_pct  = 72;
          recv_stall_pct = 0;
          set_config(8'hFF, 8'h00);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 72;
          set_config(8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        default: begin
          send_idle_pct  = 37;
          recv_stall_pct = 37;
          set_config(8'($urandom_range(7)), 8'($urandom_range(255)));
        end
      endcase
      run_traffic(325);
      in_valid_i <= 1'b0;
      drain();
    end

    if (due_replies.size() != 0) begin
      $display("%0d expected result words never arrived", due_replies.size());
      n_fail += due_replies.size();
    end

    $display("Drove %0d words (%0d from the directed table) over %0d register settings;",
             n_items, probe_word.size(), n_settings);
    $display("checked %0d results: %0d commands, %0d errors or clears, %0d tx bytes, %0d failures.",
             n_results, n_cmd, n_err, n_tx, n_fail);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/ismp_pkg.sv
sv/ismp_rxbuf.sv
sv/ismp_ctrl.sv
sv/i2c_slave_motor_packet_handler_top.sv
dv/i2c_slave_motor_packet_handler_top_tb.sv
